### hdl/mbrx_pkg.sv
// shared types, constants and the crc byte update for the modbus rtu receiver
`default_nettype none

package mbrx_pkg;

	localparam int MASK_W      = 15;
	localparam int CFG_IDX_W   = 2;
	localparam int FRAME_LEN_W = 7;

	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_MASK = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VOC_MASK  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CO2_MASK  = 2'd2;

	localparam logic [3:0]  NIB_TEMP      = 4'h3;
	localparam logic [3:0]  NIB_VOC       = 4'h5;
	localparam logic [3:0]  NIB_CO2       = 4'h4;
	localparam logic [7:0]  FUNC_READ_IN  = 8'd4;
	localparam logic [7:0]  FUNC_WRITE_MR = 8'd16;
	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'hA001;
	localparam int          MIN_CHECKED   = 6;

	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_IGNORED  = 3'd1,
		ST_ADDR_REJ = 3'd2,
		ST_FUNC_REJ = 3'd3,
		ST_DROPPED  = 3'd4,
		ST_OK       = 3'd5,
		ST_CRC_BAD  = 3'd6,
		ST_SHORT    = 3'd7
	} status_t;

	typedef struct packed {
		logic [MASK_W-1:0] temp;
		logic [MASK_W-1:0] voc;
		logic [MASK_W-1:0] co2;
	} masks_t;

	typedef struct packed {
		logic        in_sync;
		logic [15:0] crc;
		logic [7:0]  recent0;
		logic [7:0]  recent1;
		logic [7:0]  slave_address;
		logic [7:0]  function_code;
	} state_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hdl/modbus_rtu_frame_receiver.sv
// top level of the modbus rtu frame receiver: input register, frame state, result register
//
// One event (a received byte or an inter-frame gap) is accepted per clock cycle while
// req_stall is low, and its single result reaches the outputs by way of the input register
// and the result register: the event sits first in the input register, then the frame decode and the CRC-16 byte
// update are done in one pass and written to the result register together with the
// frame state. A result that is held by rsp_stall blocks at most one further event
// in the input register.
// The sensor masks are to be written through the cfg port only while no event is
// in flight (not enforced by the block); no read-back, no clearing pass after reset.
`default_nettype none

module modbus_rtu_frame_receiver #(
	parameter int MAX_FRAME_BYTES = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [mbrx_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [mbrx_pkg::MASK_W-1:0]       cfg_wdata,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic                              req_type,
	input  wire logic [7:0]                        data_byte,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic [2:0]                             status,
	output logic [7:0]                             frame_address,
	output logic [7:0]                             frame_function,
	output logic [mbrx_pkg::FRAME_LEN_W-1:0]       frame_length
);
	import mbrx_pkg::*;

	localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	masks_t            masks_q;
	state_t            state_q;
	logic [CNT_W-1:0]  count_q;

	logic              valid_s1;
	logic              req_type_s1;
	logic [7:0]        data_byte_s1;

	logic              valid_s2;
	status_t           status_s2;
	logic [7:0]        address_s2;
	logic [7:0]        function_s2;
	logic [CNT_W-1:0]  len_s2;

	state_t            nxt_state;
	logic [CNT_W-1:0]  nxt_count;
	status_t           nxt_status;
	logic [CNT_W-1:0]  nxt_len;

	logic              s2_free;
	logic              advance;
	logic              req_accept;

	assign s2_free    = !valid_s2 || !rsp_stall;
	assign advance    = valid_s1 && s2_free;
	assign req_stall  = valid_s1 && !s2_free;
	assign req_accept = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			masks_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TEMP_MASK: masks_q.temp <= cfg_wdata;
				CFG_VOC_MASK:  masks_q.voc  <= cfg_wdata;
				CFG_CO2_MASK:  masks_q.co2  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_accept) begin
			req_type_s1  <= req_type;
			data_byte_s1 <= data_byte;
		end
	end

	mbrx_frame_logic #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES),
		.CNT_W           (CNT_W)
	) u_frame_logic (
		.req_type  (req_type_s1),
		.data_byte (data_byte_s1),
		.masks     (masks_q),
		.cur       (state_q),
		.cur_count (count_q),
		.nxt       (nxt_state),
		.nxt_count (nxt_count),
		.status    (nxt_status),
		.len       (nxt_len)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.in_sync       <= 1'b0;
			state_q.crc           <= CRC_INIT;
			state_q.recent0       <= 8'h00;
			state_q.recent1       <= 8'h00;
			state_q.slave_address <= 8'h00;
			state_q.function_code <= 8'h00;
			count_q               <= '0;
		end else if (advance) begin
			state_q <= nxt_state;
			count_q <= nxt_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_s2   <= nxt_status;
			address_s2  <= nxt_state.slave_address;
			function_s2 <= nxt_state.function_code;
			len_s2      <= nxt_len;
		end
	end

	assign rsp_valid      = valid_s2;
	assign status         = status_s2;
	assign frame_address  = address_s2;
	assign frame_function = function_s2;
	assign frame_length   = FRAME_LEN_W'(len_s2);

	// a rejected address or function drops sync and restarts the frame
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (nxt_status == ST_ADDR_REJ || nxt_status == ST_FUNC_REJ))
		|=> (!state_q.in_sync && count_q == '0))
		else $error("reject did not drop sync");

	// a gap always resyncs and reloads the crc
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && req_type_s1)
		|=> (state_q.in_sync && count_q == '0 && state_q.crc == CRC_INIT))
		else $error("gap did not restart the frame");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_FRAME_BYTES))
		else $error("byte count beyond frame length");

	// ignored or dropped bytes leave the frame state alone
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (nxt_status == ST_IGNORED || nxt_status == ST_DROPPED))
		|=> ($stable(count_q) && $stable(state_q)))
		else $error("ignored byte changed frame state");

endmodule

`default_nettype wire

### hdl/mbrx_frame_logic.sv
// per-event frame decode: sync, address and function checks, crc and count update
`default_nettype none

module mbrx_frame_logic #(
	parameter int MAX_FRAME_BYTES = 64,
	parameter int CNT_W           = 7
) (
	input  wire logic               req_type,
	input  wire logic [7:0]         data_byte,
	input  wire mbrx_pkg::masks_t   masks,
	input  wire mbrx_pkg::state_t   cur,
	input  wire logic [CNT_W-1:0]   cur_count,
	output mbrx_pkg::state_t        nxt,
	output logic [CNT_W-1:0]        nxt_count,
	output mbrx_pkg::status_t       status,
	output logic [CNT_W-1:0]        len
);
	import mbrx_pkg::*;

	function automatic logic mask_hit(input logic [7:0] a, input logic [3:0] nib,
			input logic [MASK_W-1:0] mask);
		logic hit;
		hit = 1'b0;
		if (a[7:4] == nib && a[3:0] != 4'd0) begin
			hit = mask[a[3:0] - 4'd1];
		end
		return hit;
	endfunction

	logic        addr_ok;
	logic        func_ok;
	logic [15:0] got_crc;

	assign addr_ok = mask_hit(data_byte, NIB_TEMP, masks.temp) ||
	                 mask_hit(data_byte, NIB_VOC, masks.voc) ||
	                 mask_hit(data_byte, NIB_CO2, masks.co2);
	assign func_ok = (data_byte == FUNC_READ_IN) || (data_byte == FUNC_WRITE_MR);
	assign got_crc = {cur.recent1, cur.recent0};

	always_comb begin
		nxt       = cur;
		nxt_count = cur_count;
		status    = ST_STORED;
		len       = cur_count;
		priority if (req_type) begin
			if (cur_count > CNT_W'(MIN_CHECKED)) begin
				status = (got_crc == cur.crc) ? ST_OK : ST_CRC_BAD;
			end else begin
				status = ST_SHORT;
			end
			nxt.in_sync = 1'b1;
			nxt.crc     = CRC_INIT;
			nxt.recent0 = 8'h00;
			nxt.recent1 = 8'h00;
			nxt_count   = '0;
		end else if (!cur.in_sync) begin
			status = ST_IGNORED;
		end else if (cur_count >= CNT_W'(MAX_FRAME_BYTES)) begin
			status = ST_DROPPED;
		end else begin
			if (cur_count == CNT_W'(0)) begin
				if (addr_ok) begin
					nxt.slave_address = data_byte;
				end else begin
					status = ST_ADDR_REJ;
				end
			end else if (cur_count == CNT_W'(1)) begin
				if (func_ok) begin
					nxt.function_code = data_byte;
				end else begin
					status = ST_FUNC_REJ;
				end
			end
			if (status == ST_STORED) begin
				if (cur_count >= CNT_W'(2)) begin
					nxt.crc = crc_feed(cur.crc, cur.recent0);
				end
				nxt.recent0 = cur.recent1;
				nxt.recent1 = data_byte;
				nxt_count   = cur_count + CNT_W'(1);
			end else begin
				nxt.in_sync = 1'b0;
				nxt.crc     = CRC_INIT;
				nxt.recent0 = 8'h00;
				nxt.recent1 = 8'h00;
				nxt_count   = '0;
			end
			len = nxt_count;
		end
	end

endmodule

`default_nettype wire

### dv/tb_top.sv
// self-checking testbench for the modbus rtu frame receiver: directed and random frames
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import mbrx_pkg::*;

	localparam int MAX_BYTES  = 64;
	localparam int IDLE_LIMIT = 4000;

	typedef struct {
		status_t    status;
		logic [7:0] address;
		logic [7:0] func;
		logic [6:0] frame_len;
	} rsp_t;

	logic                   clk;
	logic                   arst_n    = 1'b0;
	logic                   cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = CFG_TEMP_MASK;
	logic [MASK_W-1:0]      cfg_wdata = '0;
	logic                   req_valid = 1'b0;
	logic                   req_stall;
	logic                   req_type  = 1'b0;
	logic [7:0]             data_byte = 8'h00;
	logic                   rsp_valid;
	logic                   rsp_stall = 1'b0;
	logic [2:0]             status;
	logic [7:0]             frame_address;
	logic [7:0]             frame_function;
	logic [FRAME_LEN_W-1:0] frame_length;

	modbus_rtu_frame_receiver #(.MAX_FRAME_BYTES(MAX_BYTES)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req_type      (req_type),
		.data_byte     (data_byte),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.status        (status),
		.frame_address (frame_address),
		.frame_function(frame_function),
		.frame_length  (frame_length)
	);

	// receiver model state
	logic [MASK_W-1:0] mask_temp, mask_voc, mask_co2;
	logic              rx_sync;
	int                rx_count;
	logic [15:0]       rx_crc;
	logic [7:0]        rx_prev0, rx_prev1;
	logic [7:0]        rx_addr, rx_func;

	rsp_t expected_rsp[$];
	int   counted_events = 0;
	int   fail_count     = 0;
	int   idle_cycles    = 0;
	int   stall_left     = 0;
	bit   quiet_run      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		logic        fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c  = c >> 1;
			if (fb) begin
				c = c ^ 16'hA001;
			end
		end
		return c;
	endfunction

	function automatic bit address_hit(input logic [7:0] a);
		int lo;
		lo = a[3:0];
		if (lo == 0) begin
			return 1'b0;
		end
		case (a[7:4])
			NIB_TEMP: return mask_temp[lo-1];
			NIB_VOC:  return mask_voc[lo-1];
			NIB_CO2:  return mask_co2[lo-1];
			default:  return 1'b0;
		endcase
	endfunction

	function automatic void clear_frame();
		rx_count = 0;
		rx_crc   = CRC_INIT;
		rx_prev0 = 8'h00;
		rx_prev1 = 8'h00;
	endfunction

	function automatic rsp_t predict_event(input logic t, input logic [7:0] b);
		rsp_t    r;
		status_t st;
		if (t) begin
			r.frame_len = 7'(rx_count);
			if (rx_count > MIN_CHECKED) begin
				st = ({rx_prev1, rx_prev0} == rx_crc) ? ST_OK : ST_CRC_BAD;
			end else begin
				st = ST_SHORT;
			end
			rx_sync = 1'b1;
			clear_frame();
		end else if (!rx_sync) begin
			st          = ST_IGNORED;
			r.frame_len = 7'(rx_count);
		end else if (rx_count >= MAX_BYTES) begin
			st          = ST_DROPPED;
			r.frame_len = 7'(rx_count);
		end else begin
			st = ST_STORED;
			if (rx_count == 0) begin
				if (address_hit(b)) begin
					rx_addr = b;
				end else begin
					st = ST_ADDR_REJ;
				end
			end else if (rx_count == 1) begin
				if (b == FUNC_READ_IN || b == FUNC_WRITE_MR) begin
					rx_func = b;
				end else begin
					st = ST_FUNC_REJ;
				end
			end
			if (st == ST_STORED) begin
				if (rx_count >= 2) begin
					rx_crc = crc16_update(rx_crc, rx_prev0);
				end
				rx_prev0 = rx_prev1;
				rx_prev1 = b;
				rx_count++;
			end else begin
				rx_sync = 1'b0;
				clear_frame();
			end
			r.frame_len = 7'(rx_count);
		end
		r.status  = st;
		r.address = rx_addr;
		r.func    = rx_func;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (quiet_run) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] pick_address();
		logic [7:0] a;
		a = 8'h00;
		for (int n = 0; n < 24; n++) begin
			case ($urandom_range(0, 2))
				0:       a = {NIB_TEMP, 4'($urandom_range(0, 15))};
				1:       a = {NIB_VOC, 4'($urandom_range(0, 15))};
				default: a = {NIB_CO2, 4'($urandom_range(0, 15))};
			endcase
			if (address_hit(a)) begin
				return a;
			end
		end
		return a;
	endfunction

	task automatic send_event(input logic t, input logic [7:0] b);
		rsp_t e;
		int   g;
		req_valid <= 1'b1;
		req_type  <= t;
		data_byte <= b;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		e = predict_event(t, b);
		expected_rsp.push_back(e);
		counted_events++;
		g = pick_gap();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic send_frame(input logic [7:0] a, input logic [7:0] f, input int npay,
			input bit crc_good, input int extra);
		logic [7:0]  fb[$];
		logic [15:0] c;
		fb = {};
		fb.push_back(a);
		fb.push_back(f);
		repeat (npay) fb.push_back(8'($urandom));
		c = CRC_INIT;
		foreach (fb[k]) c = crc16_update(c, fb[k]);
		if (!crc_good) begin
			c = c ^ (16'h0001 << $urandom_range(0, 15));
		end
		fb.push_back(c[7:0]);
		fb.push_back(c[15:8]);
		repeat (extra) fb.push_back(8'($urandom));
		foreach (fb[k]) send_event(1'b0, fb[k]);
		send_event(1'b1, 8'($urandom));
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_masks(input logic [MASK_W-1:0] t, input logic [MASK_W-1:0] v,
			input logic [MASK_W-1:0] c);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TEMP_MASK;
		cfg_wdata <= t;
		@(posedge clk);
		cfg_index <= CFG_VOC_MASK;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_index <= CFG_CO2_MASK;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we    <= 1'b0;
		mask_temp = t;
		mask_voc  = v;
		mask_co2  = c;
	endtask

	task automatic test_before_sync();
		send_event(1'b0, 8'h00);
		send_event(1'b0, 8'hFF);
		send_event(1'b1, 8'hFF);
	endtask

	task automatic test_address_reject();
		send_event(1'b0, 8'h5E);
		send_event(1'b1, 8'h00);
		send_event(1'b0, 8'h30);
		send_event(1'b1, 8'h00);
	endtask

	task automatic test_function_reject();
		send_event(1'b0, 8'h41);
		send_event(1'b0, 8'h03);
		send_event(1'b1, 8'h00);
	endtask

	task automatic test_length_and_crc();
		send_frame(8'h31, FUNC_READ_IN, 3, 1'b1, 0);
		send_frame(8'h41, FUNC_WRITE_MR, 2, 1'b1, 0);
		send_frame(8'h5F, FUNC_WRITE_MR, 3, 1'b0, 0);
	endtask

	task automatic test_random_traffic(input int target);
		int start;
		int r;
		int npay;
		int extra;
		start = counted_events;
		while (counted_events - start < target) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				extra = 0;
				if ($urandom_range(0, 19) == 0) begin
					npay  = $urandom_range(0, 1) ? 60 : $urandom_range(40, 66);
					extra = $urandom_range(1, 6);
				end else begin
					npay = $urandom_range(0, 10);
					if ($urandom_range(0, 9) == 0) begin
						extra = $urandom_range(1, 3);
					end
				end
				send_frame(pick_address(), $urandom_range(0, 1) ? FUNC_READ_IN : FUNC_WRITE_MR,
					npay, $urandom_range(0, 9) != 0, extra);
			end else if (r < 85) begin
				send_frame($urandom_range(0, 1) ? pick_address() : 8'($urandom),
					$urandom_range(0, 2) == 0 ? FUNC_READ_IN : 8'($urandom),
					$urandom_range(0, 8), $urandom_range(0, 1), 0);
			end else begin
				repeat ($urandom_range(1, 12)) send_event($urandom_range(0, 7) == 0, 8'($urandom));
			end
		end
	endtask

	// result checking, response back-pressure and watchdog
	always @(posedge clk) begin
		rsp_t e;
		int   r;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("unexpected transaction: status %0d addr %h func %h len %0d",
							status, frame_address, frame_function, frame_length);
					end
				end else begin
					e = expected_rsp.pop_front();
					if (status != e.status || frame_address != e.address ||
						frame_function != e.func || frame_length != e.frame_len) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("mismatch: status %0d/%0d addr %h/%h func %h/%h len %0d/%0d",
								e.status, status, e.address, frame_address,
								e.func, frame_function, e.frame_len, frame_length);
						end
					end
				end
			end

			if (quiet_run) begin
				rsp_stall  <= 1'b0;
				stall_left <= 0;
			end else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					rsp_stall  <= 1'b0;
					stall_left <= $urandom_range(1, 8);
				end else if (r < 92) begin
					rsp_stall  <= 1'b1;
					stall_left <= $urandom_range(0, 2);
				end else begin
					rsp_stall  <= 1'b1;
					stall_left <= $urandom_range(10, 40);
				end
			end

			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("FAIL modbus_rtu_frame_receiver");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		mask_temp = '0;
		mask_voc  = '0;
		mask_co2  = '0;
		rx_sync   = 1'b0;
		rx_addr   = 8'h00;
		rx_func   = 8'h00;
		clear_frame();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_masks(15'h7FFF, 15'h4000, 15'h0001);
		test_before_sync();
		test_address_reject();
		test_function_reject();
		test_length_and_crc();

		wait_idle();
		set_masks(15'h7FFF, 15'h7FFF, 15'h7FFF);
		test_random_traffic(400);

		wait_idle();
		set_masks(15'h0000, 15'h0000, 15'h0000);
		test_random_traffic(100);

		wait_idle();
		set_masks(15'($urandom), 15'($urandom), 15'($urandom));
		quiet_run = 1'b1;
		test_random_traffic(300);
		quiet_run = 1'b0;

		wait_idle();
		set_masks(15'h0001, 15'h4000, 15'h2AAA);
		test_random_traffic(300);

		wait_idle();
		set_masks(15'($urandom), 15'($urandom), 15'($urandom));
		test_random_traffic(500);

		req_valid <= 1'b0;
		while (expected_rsp.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_rsp.size() == 0) begin
			$display("PASS modbus_rtu_frame_receiver");
		end else begin
			$display("FAIL modbus_rtu_frame_receiver");
		end
		$finish;
	end

endmodule

### files.f
hdl/mbrx_pkg.sv
hdl/mbrx_frame_logic.sv
hdl/modbus_rtu_frame_receiver.sv
dv/tb_top.sv
